>>> src/md5_pkg.sv
// md5 stream hasher package: state enum, constants, round tables
// used by md5_ctrl, md5_dp and md5_stream_hasher_top
`timescale 1ns / 1ps
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } md5_state_t;

  // store byte source
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } md5_src_t;

  typedef struct packed {
    logic       wr;
    md5_src_t   src;
    logic       add_bits;
    logic       comp_start;
    logic       comp_step;
    logic       comp_fold;
    logic       init;
    logic       latch_len;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       block_full;
    logic [5:0] round;
  } md5_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_idx(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

>>> src/md5_ctrl.sv
// md5 controller: byte intake, compression sequencing, padding, digest output
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_has_byte,
  input  logic              in_eom,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_idx,
  output md5_pkg::md5_cmd_t cmd,
  input  md5_pkg::md5_sts_t sts
);
  import md5_pkg::*;

  md5_state_t state_r, state_nxt;
  logic       eom_r, eom_nxt;    // finishing a message
  logic       padded_r, padded_nxt;
  logic       len_blk_r, len_blk_nxt;  // current block carries the length
  logic [1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      eom_r     <= 1'b0;
      padded_r  <= 1'b0;
      len_blk_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      eom_r     <= eom_nxt;
      padded_r  <= padded_nxt;
      len_blk_r <= len_blk_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    eom_nxt     = eom_r;
    padded_nxt  = padded_r;
    len_blk_nxt = len_blk_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.src     = SRC_DATA;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr       = in_has_byte;
          cmd.add_bits = in_has_byte;
          cmd.latch_len = in_eom;
          eom_nxt      = in_eom;
          padded_nxt   = 1'b0;
          if (in_has_byte && sts.block_full) begin
            cmd.comp_start = 1'b1;
            state_nxt      = ST_COMP;
          end else if (in_eom) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        cmd.comp_step = 1'b1;
        if (sts.round == 6'd63) begin
          cmd.comp_fold = 1'b1;
          state_nxt     = eom_r ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.wr = 1'b1;
        if (!padded_r) begin
          cmd.src     = SRC_PAD;
          padded_nxt  = 1'b1;
          len_blk_nxt = sts.fill[5:3] != 3'd7;
        end else if (len_blk_r && sts.fill[5:3] == 3'd7) begin
          cmd.src = SRC_LEN;
        end else begin
          cmd.src = SRC_ZERO;
        end
        if (sts.block_full) begin
          cmd.comp_start = 1'b1;
          // the length byte at position 63 ends the message
          if (padded_r && len_blk_r) eom_nxt = 1'b0;
          else len_blk_nxt = 1'b1;
          state_nxt = ST_COMP;
        end
        // after the last block the compression goes on to ST_OUT with eom cleared
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cmd.init  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // finished last block of a message: go to output
    if (state_r == ST_COMP && sts.round == 6'd63 && !eom_r && padded_r) begin
      state_nxt = ST_OUT;
    end
  end

  assign out_idx = idx_r;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("output and intake overlap");
  a_idx_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_OUT) |-> idx_r == 2'd0)
    else $error("word index not reset");
  a_comp_from_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_start |-> sts.block_full && cmd.wr)
    else $error("compression without full block");
endmodule

>>> src/md5_dp.sv
// md5 datapath: block store memory, bit count, chaining words, round unit
// depends on md5_pkg
`timescale 1ns / 1ps
module md5_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  md5_pkg::md5_cmd_t cmd,
  output md5_pkg::md5_sts_t sts,
  input  logic [1:0]        out_idx,
  output logic [31:0]       out_word
);
  import md5_pkg::*;

  logic [31:0] mem [0:15];   // block store as 16 words
  logic [5:0]  fill_r;
  logic [63:0] bits_r, len_r;
  logic [31:0] h_r [0:3];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [31:0] m_r;
  logic [7:0]  wbyte;
  logic [31:0] f, t, rt;
  logic [5:0]  rnd_nxt;

  always_comb begin
    unique case (cmd.src)
      SRC_DATA: wbyte = in_byte;
      SRC_PAD:  wbyte = PAD_BYTE;
      SRC_ZERO: wbyte = 8'h00;
      default:  wbyte = len_r[8 * fill_r[2:0] +: 8];
    endcase
  end

  // read address for the next round, registered message word
  assign rnd_nxt = cmd.comp_start ? 6'd0 : rnd_r + 6'd1;

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[fill_r[5:2]][8 * fill_r[1:0] +: 8] <= wbyte;
    m_r <= mem[msg_idx(rnd_nxt)];
  end

  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t  = a_r + f + m_r + round_k(rnd_r);
    rt = (t << rot_s(rnd_r)) | (t >> (6'd32 - {1'b0, rot_s(rnd_r)}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bits_r <= '0;
      h_r[0] <= INIT_A; h_r[1] <= INIT_B; h_r[2] <= INIT_C; h_r[3] <= INIT_D;
    end else begin
      if (cmd.wr) fill_r <= fill_r + 6'd1;
      if (cmd.add_bits) bits_r <= bits_r + 64'd8;
      if (cmd.comp_fold) begin
        h_r[0] <= h_r[0] + d_r;
        h_r[1] <= h_r[1] + b_r + rt;
        h_r[2] <= h_r[2] + b_r;
        h_r[3] <= h_r[3] + c_r;
      end
      if (cmd.init) begin
        fill_r <= '0;
        bits_r <= '0;
        h_r[0] <= INIT_A; h_r[1] <= INIT_B; h_r[2] <= INIT_C; h_r[3] <= INIT_D;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) len_r <= bits_r + (cmd.add_bits ? 64'd8 : 64'd0);
    if (cmd.comp_start) begin
      a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
      rnd_r <= 6'd0;
    end else if (cmd.comp_step) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rt;
      rnd_r <= rnd_nxt;
    end
  end

  assign sts.fill       = fill_r;
  assign sts.block_full = fill_r == 6'd63;
  assign sts.round      = rnd_r;
  assign out_word       = h_r[out_idx];

  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && cmd.src == SRC_LEN) |-> fill_r[5:3] == LEN_POS[5:3])
    else $error("length byte out of place");
  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_fold |-> fill_r == 6'd0)
    else $error("store not empty at fold");
  a_no_wr_comp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.comp_step |-> !cmd.wr)
    else $error("store written during compression");
endmodule

>>> src/md5_stream_hasher_top.sv
// md5 stream hasher top level: joins md5_ctrl and md5_dp
// depends on md5_pkg, md5_ctrl, md5_dp
//
// channel  dir  tdata                 tuser
// in       in   data_byte[7:0]        has_byte, tlast = end_of_message
// out      out  digest_word[31:0]     word_index[1:0], tlast = last_word
//
// one byte per cycle when in_tready is high; a full block starts compression
// end of message pads one byte a cycle, compressing each padded block,
// then four output transactions; in_tready low from then until the last word
// synchronous active-low reset restores the initial chaining words
// out_tready low holds the current word
`timescale 1ns / 1ps
module md5_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [1:0]  out_tuser,  // word_index
  output logic        out_tlast
);
  import md5_pkg::*;

  md5_cmd_t   cmd;
  md5_sts_t   sts;
  logic [1:0] idx;

  md5_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_has_byte(in_tuser),
    .in_eom(in_tlast), .in_ready(in_tready), .out_valid(out_tvalid),
    .out_ready(out_tready), .out_idx(idx), .cmd(cmd), .sts(sts)
  );

  md5_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_byte(in_tdata), .cmd(cmd), .sts(sts),
    .out_idx(idx), .out_word(out_tdata)
  );

  assign out_tuser = idx;
  assign out_tlast = idx == 2'd3;
endmodule
